>>> sv/emc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emc_pkg: shared types and microcode for the ElGamal modular cipher
// Word types, register indexes, sequencer phases and the per-operation
// microprogram that drives the shared modular multiplier.
// ----------------------------------------------------------------------------
package emc_pkg;

  localparam int ModBits = 16;
  localparam int CntBits = $clog2(ModBits);

  typedef logic [ModBits-1:0] word_t;
  typedef word_t [3:0]        tmp_file_t;
  typedef logic [2:0]         pc_t;
  typedef logic [1:0]         slot_t;
  typedef logic [1:0]         cfg_idx_t;

  // Reset values of the configuration registers
  localparam word_t ModulusReset   = word_t'(1549);
  localparam word_t GeneratorReset = word_t'(2);
  localparam word_t KeyReset       = word_t'(1234);

  // Configuration register indexes
  localparam cfg_idx_t CFG_MODULUS   = 2'd0;
  localparam cfg_idx_t CFG_GENERATOR = 2'd1;
  localparam cfg_idx_t CFG_KEY       = 2'd2;

  // Temporary slots
  localparam slot_t SLOT_T0 = 2'd0;
  localparam slot_t SLOT_T1 = 2'd1;
  localparam slot_t SLOT_T2 = 2'd2;
  localparam slot_t SLOT_T3 = 2'd3;

  typedef enum logic [1:0] {
    OP_ENCRYPT = 2'd0,
    OP_DECRYPT = 2'd1,
    OP_COMBINE = 2'd2
  } op_t;

  typedef struct packed {
    op_t   op;
    word_t message;
    word_t nonce;
    word_t first_c1;
    word_t first_c2;
    word_t second_c1;
    word_t second_c2;
  } in_word_t;

  typedef struct packed {
    word_t result_a;
    word_t result_b;
  } out_word_t;

  typedef struct packed {
    word_t modulus;
    word_t generator;
    word_t private_key;
  } cfg_regs_t;

  // Operand sources for the multiplier
  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_GEN,
    SRC_KEY,
    SRC_MSG,
    SRC_NONCE,
    SRC_FC1,
    SRC_FC2,
    SRC_SC1,
    SRC_SC2,
    SRC_PM2,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3
  } src_t;

  typedef enum logic [1:0] {
    UOP_MUL,
    UOP_POW,
    UOP_END
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t kind;
    src_t      sa;
    src_t      sb;
    slot_t     dst;
  } uop_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FETCH,
    PH_MWAIT,
    PH_PCHK,
    PH_PACC,
    PH_PSQR,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } seq_stat_t;

  function automatic uop_t mk_uop(uop_kind_t kind, src_t sa, src_t sb, slot_t dst);
    uop_t u;
    u.kind = kind;
    u.sa   = sa;
    u.sb   = sb;
    u.dst  = dst;
    return u;
  endfunction

  // Microprogram: a reduction is a multiply by one, a power runs square-and-multiply
  function automatic uop_t ucode(op_t op, pc_t pc);
    uop_t u;
    u = mk_uop(UOP_END, SRC_ZERO, SRC_ZERO, SLOT_T0);
    case (op)
      OP_ENCRYPT: begin
        case (pc)
          3'd0:    u = mk_uop(UOP_MUL, SRC_ONE, SRC_GEN,   SLOT_T0);
          3'd1:    u = mk_uop(UOP_MUL, SRC_ONE, SRC_MSG,   SLOT_T1);
          3'd2:    u = mk_uop(UOP_POW, SRC_T0,  SRC_KEY,   SLOT_T2);
          3'd3:    u = mk_uop(UOP_POW, SRC_T0,  SRC_NONCE, SLOT_T3);
          3'd4:    u = mk_uop(UOP_POW, SRC_T2,  SRC_NONCE, SLOT_T2);
          3'd5:    u = mk_uop(UOP_MUL, SRC_T1,  SRC_T2,    SLOT_T2);
          default: u = mk_uop(UOP_END, SRC_ZERO, SRC_ZERO, SLOT_T0);
        endcase
      end
      OP_DECRYPT: begin
        case (pc)
          3'd0:    u = mk_uop(UOP_MUL, SRC_ONE, SRC_FC1,  SLOT_T0);
          3'd1:    u = mk_uop(UOP_MUL, SRC_ONE, SRC_FC2,  SLOT_T1);
          3'd2:    u = mk_uop(UOP_POW, SRC_T0,  SRC_KEY,  SLOT_T2);
          3'd3:    u = mk_uop(UOP_POW, SRC_T2,  SRC_PM2,  SLOT_T2);
          3'd4:    u = mk_uop(UOP_MUL, SRC_T1,  SRC_T2,   SLOT_T3);
          3'd5:    u = mk_uop(UOP_MUL, SRC_ONE, SRC_ZERO, SLOT_T2);
          default: u = mk_uop(UOP_END, SRC_ZERO, SRC_ZERO, SLOT_T0);
        endcase
      end
      OP_COMBINE: begin
        case (pc)
          3'd0:    u = mk_uop(UOP_MUL, SRC_ONE, SRC_FC1, SLOT_T0);
          3'd1:    u = mk_uop(UOP_MUL, SRC_ONE, SRC_SC1, SLOT_T1);
          3'd2:    u = mk_uop(UOP_MUL, SRC_T0,  SRC_T1,  SLOT_T3);
          3'd3:    u = mk_uop(UOP_MUL, SRC_ONE, SRC_FC2, SLOT_T0);
          3'd4:    u = mk_uop(UOP_MUL, SRC_ONE, SRC_SC2, SLOT_T1);
          3'd5:    u = mk_uop(UOP_MUL, SRC_T0,  SRC_T1,  SLOT_T2);
          default: u = mk_uop(UOP_END, SRC_ZERO, SRC_ZERO, SLOT_T0);
        endcase
      end
      default: u = mk_uop(UOP_END, SRC_ZERO, SRC_ZERO, SLOT_T0);
    endcase
    return u;
  endfunction

  // Select one multiplier operand
  function automatic word_t pick(src_t s, in_word_t w, cfg_regs_t c, tmp_file_t t);
    word_t v;
    case (s)
      SRC_ZERO:  v = '0;
      SRC_ONE:   v = word_t'(1);
      SRC_GEN:   v = c.generator;
      SRC_KEY:   v = c.private_key;
      SRC_MSG:   v = w.message;
      SRC_NONCE: v = w.nonce;
      SRC_FC1:   v = w.first_c1;
      SRC_FC2:   v = w.first_c2;
      SRC_SC1:   v = w.second_c1;
      SRC_SC2:   v = w.second_c2;
      SRC_PM2:   v = c.modulus - word_t'(2);
      SRC_T0:    v = t[SLOT_T0];
      SRC_T1:    v = t[SLOT_T1];
      SRC_T2:    v = t[SLOT_T2];
      SRC_T3:    v = t[SLOT_T3];
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/elgamal_modular_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgamal_modular_cipher: textbook ElGamal encrypt, decrypt and combine
// Top level: configuration registers, input capture and output register
// around the microcoded sequencer and its shared modular multiplier.
// ----------------------------------------------------------------------------
// One word is processed at a time; in_ready is low while it is worked on.
// Every step goes through one bit-serial modular multiplier. A power with a
// 16-bit exponent costs up to 32 multiplies plus an exponent check per bit.
// Encrypt runs three such powers plus three other multiplies; decrypt runs
// two powers (the second with exponent p - 2) plus four multiplies; combine
// runs six multiplies. With a modulus below two, or an unused op code, the
// result (all zero) is ready and no multiply is run. A finished result waits
// in an output register, so the next word may be accepted before it is taken.
// Configuration writes are taken in any cycle and must only be made while
// the block is idle.
module elgamal_modular_cipher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  emc_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output emc_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  emc_pkg::cfg_idx_t   cfg_index,
  input  emc_pkg::word_t      cfg_data
);
  import emc_pkg::*;

  cfg_regs_t cfg_r;
  seq_stat_t seq_stat;
  out_word_t seq_res;
  logic      in_take;
  logic      res_take;
  logic      out_valid_r;
  out_word_t out_data_r;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.modulus     <= ModulusReset;
      cfg_r.generator   <= GeneratorReset;
      cfg_r.private_key <= KeyReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODULUS:   cfg_r.modulus     <= cfg_data;
        CFG_GENERATOR: cfg_r.generator   <= cfg_data;
        CFG_KEY:       cfg_r.private_key <= cfg_data;
        default:       cfg_r             <= cfg_r;
      endcase
    end
  end

  // Accept a word only when the sequencer is idle
  assign in_ready = seq_stat.idle;
  assign in_take  = in_valid && in_ready;

  // Move the result into the output register when it is free
  assign res_take = seq_stat.res_valid && (!out_valid_r || out_ready);

  emc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_take),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .res_take (res_take),
    .stat     (seq_stat),
    .res      (seq_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/emc_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emc_modmul: bit-serial modular multiplier
// Computes a * b mod p one bit of b per cycle, most significant bit first,
// with two conditional subtractions per step. Needs a below p.
// ----------------------------------------------------------------------------
module emc_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  emc_pkg::word_t   a,
  input  emc_pkg::word_t   b,
  input  emc_pkg::word_t   p,
  output emc_pkg::word_t   result,
  output emc_pkg::mm_stat_t stat
);
  import emc_pkg::*;

  logic               run_r;
  logic               done_r;
  logic [CntBits-1:0] cnt_r;
  word_t              acc_r;
  word_t              a_r;
  word_t              b_r;

  logic [ModBits:0] dbl;
  logic [ModBits:0] dbl_red;
  logic [ModBits:0] sum;
  logic [ModBits:0] sum_red;

  // Double, reduce, add the partial product, reduce again
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
    sum     = dbl_red + (b_r[ModBits-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
  end

  // Sequence the bit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntBits'(ModBits - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Hold operands and advance the accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (run_r) begin
      acc_r <= sum_red[ModBits-1:0];
      b_r   <= {b_r[ModBits-2:0], 1'b0};
    end
  end

  assign result    = acc_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("multiplier done held for more than one cycle");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r)
    else $error("multiplier started while still running");

endmodule

>>> sv/emc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emc_seq: microcoded sequencer for the ElGamal operations
// Steps through the microprogram of the captured operation, runs modular
// powers by square-and-multiply and keeps the intermediate values.
// ----------------------------------------------------------------------------
module emc_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  emc_pkg::in_word_t   in_data,
  input  emc_pkg::cfg_regs_t  cfg,
  input  logic                res_take,
  output emc_pkg::seq_stat_t  stat,
  output emc_pkg::out_word_t  res
);
  import emc_pkg::*;

  phase_t    state_r;
  phase_t    state_nxt;
  pc_t       pc_r;
  pc_t       pc_nxt;
  in_word_t  word_r;
  tmp_file_t tmp_r;
  word_t     acc_r;
  word_t     base_r;
  word_t     exp_r;

  uop_t      uop;
  logic      mm_start;
  word_t     mm_a;
  word_t     mm_b;
  word_t     mm_res;
  mm_stat_t  mm_stat;
  logic      bypass;

  assign uop    = ucode(word_r.op, pc_r);
  assign bypass = (cfg.modulus < word_t'(2));

  emc_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .p      (cfg.modulus),
    .result (mm_res),
    .stat   (mm_stat)
  );

  // Next phase
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PH_IDLE:  if (start) state_nxt = bypass ? PH_DONE : PH_FETCH;
      PH_FETCH: begin
        unique case (uop.kind)
          UOP_MUL: state_nxt = PH_MWAIT;
          UOP_POW: state_nxt = PH_PCHK;
          default: state_nxt = PH_DONE;
        endcase
      end
      PH_MWAIT: if (mm_stat.done) state_nxt = PH_FETCH;
      PH_PCHK: begin
        priority if (exp_r == '0) state_nxt = PH_FETCH;
        else if (exp_r[0])        state_nxt = PH_PACC;
        else                      state_nxt = PH_PSQR;
      end
      PH_PACC:  if (mm_stat.done) state_nxt = PH_PSQR;
      PH_PSQR:  if (mm_stat.done) state_nxt = PH_PCHK;
      PH_DONE:  if (res_take) state_nxt = PH_IDLE;
      default:  state_nxt = PH_IDLE;
    endcase
  end

  // Multiplier requests
  always_comb begin
    mm_start = 1'b0;
    mm_a     = '0;
    mm_b     = '0;
    unique case (state_r)
      PH_FETCH: begin
        if (uop.kind == UOP_MUL) begin
          mm_start = 1'b1;
          mm_a     = pick(uop.sa, word_r, cfg, tmp_r);
          mm_b     = pick(uop.sb, word_r, cfg, tmp_r);
        end
      end
      PH_PCHK: begin
        if (exp_r != '0) begin
          mm_start = 1'b1;
          mm_a     = exp_r[0] ? acc_r : base_r;
          mm_b     = base_r;
        end
      end
      PH_PACC: begin
        if (mm_stat.done) begin
          mm_start = 1'b1;
          mm_a     = base_r;
          mm_b     = base_r;
        end
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  // Advance the program counter
  always_comb begin
    pc_nxt = pc_r;
    priority if (state_r == PH_IDLE && start)                   pc_nxt = '0;
    else if (state_r == PH_MWAIT && mm_stat.done)               pc_nxt = pc_r + 1'b1;
    else if (state_r == PH_PCHK && exp_r == '0)                 pc_nxt = pc_r + 1'b1;
    else                                                        pc_nxt = pc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      PH_IDLE: begin
        if (start) begin
          word_r         <= in_data;
          tmp_r[SLOT_T2] <= '0;
          tmp_r[SLOT_T3] <= '0;
        end
      end
      PH_FETCH: begin
        if (uop.kind == UOP_POW) begin
          acc_r  <= word_t'(1);
          base_r <= pick(uop.sa, word_r, cfg, tmp_r);
          exp_r  <= pick(uop.sb, word_r, cfg, tmp_r);
        end
      end
      PH_MWAIT: if (mm_stat.done) tmp_r[uop.dst] <= mm_res;
      PH_PCHK:  if (exp_r == '0) tmp_r[uop.dst] <= acc_r;
      PH_PACC:  if (mm_stat.done) acc_r <= mm_res;
      PH_PSQR: begin
        if (mm_stat.done) begin
          base_r <= mm_res;
          exp_r  <= exp_r >> 1;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  assign stat.idle      = (state_r == PH_IDLE);
  assign stat.res_valid = (state_r == PH_DONE);
  assign res.result_a   = tmp_r[SLOT_T3];
  assign res.result_b   = tmp_r[SLOT_T2];

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == PH_IDLE))
    else $error("word accepted while sequencer busy");

  a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> (state_r == PH_DONE))
    else $error("result taken before it was ready");

  a_wait_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PH_MWAIT || state_r == PH_PACC || state_r == PH_PSQR)
      |-> (mm_stat.busy || mm_stat.done))
    else $error("waiting on a multiplier that is not running");

endmodule
